// ----- rtl/segmented_sieve_marker_core_assert.svh -----
// Assertion macros for the segmented sieve marker core.
`ifndef SEGMENTED_SIEVE_MARKER_CORE_ASSERT_SVH
`define SEGMENTED_SIEVE_MARKER_CORE_ASSERT_SVH
// Same-cycle implication, clocked on clk, off during reset.
`define SSM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define SSM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/ssm_pkg.sv -----
// Shared types and constants of the segmented sieve marker.
package ssm_pkg;
	localparam int PRIME_SLOTS   = 4096;
	localparam int MAX_LAYERS    = 16;
	localparam int SEGMENT_BITS  = 1024;
	localparam int BITS_PER_WORD = 64;
	localparam int SEG_WORDS     = SEGMENT_BITS / BITS_PER_WORD;
	localparam int SLOT_W        = $clog2(PRIME_SLOTS);
	localparam int LAYER_W       = $clog2(MAX_LAYERS);
	localparam int OFF_W         = $clog2(SEGMENT_BITS);
	localparam int WSEL_W        = $clog2(SEG_WORDS);
	localparam int PRIME_W       = 24;
	localparam int POS_W         = 32;
	localparam int SEGNUM_W      = 22;
	localparam int CFG_W         = 13;
	localparam int APOS_W        = POS_W + 2;
	localparam logic [POS_W-1:0] NEVER_POS = '1;

	typedef enum logic [1:0] {
		KIND_PRIME = 2'd0,
		KIND_POS   = 2'd1,
		KIND_SIEVE = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_FIRST = 2'd0,
		REG_END   = 2'd1
	} reg_idx_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD   = 7'b0000010,
		ST_CHK  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_MARK = 7'b0010000,
		ST_WB   = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;
endpackage

// ----- rtl/ssm_rem_unit.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module ssm_rem_unit import ssm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [POS_W-1:0]   dividend,
	input  logic [PRIME_W-1:0] divisor,
	output logic               done,
	output logic [PRIME_W-1:0] remainder
);
	localparam int CNT_W = $clog2(POS_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [POS_W-1:0]   dvd_q;
	logic [PRIME_W-1:0] rem_q;
	logic [PRIME_W-1:0] dsr_q;
	logic [PRIME_W:0]   trial;
	logic [PRIME_W:0]   diff;
	logic [PRIME_W-1:0] rem_nxt;

	assign trial   = {rem_q, dvd_q[POS_W-1]};
	assign diff    = trial - {1'b0, dsr_q};
	assign rem_nxt = (trial >= {1'b0, dsr_q}) ? diff[PRIME_W-1:0] : trial[PRIME_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(POS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[POS_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule

// ----- rtl/segmented_sieve_marker_core.sv -----
// Segmented sieve marker core: prime/position tables, segment marking, word output.
// A request other than a sieve is done when it is accepted. A sieve walks the prime
// slots from first_prime_slot up to but not including min(end_prime_slot, 4096) one
// at a time through one sequencer: a slot with a zero prime or a never position
// only passes table read and check; any other slot passes table read, check, final
// segment compare and write-back, plus the bit-serial remainder unit when the saved
// position lies before the segment, plus one mark per hit inside the 1024-bit
// segment. The 16 result words then leave one per cycle while the output side
// accepts. s_tready is low for the whole sieve.
// The tables have no reset; entries must be loaded before they are sieved.
module segmented_sieve_marker_core import ssm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// prime_slot[11:0], layer[15:12], prime_value[39:16], position_value[71:40],
	// segment_number[93:72], zero[95:94]
	input  logic [95:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// word_offset[3:0], composite_bits[67:4], zero[71:68]
	output logic [71:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	`include "segmented_sieve_marker_core_assert.svh"

	logic [SLOT_W-1:0]   in_slot;
	logic [LAYER_W-1:0]  in_layer;
	logic [PRIME_W-1:0]  in_prime;
	logic [POS_W-1:0]    in_pos;
	logic [SEGNUM_W-1:0] in_seg;
	logic                acc;

	assign in_slot  = s_tdata[11:0];
	assign in_layer = s_tdata[15:12];
	assign in_prime = s_tdata[39:16];
	assign in_pos   = s_tdata[71:40];
	assign in_seg   = s_tdata[93:72];

	state_t                    state_q;
	logic [CFG_W-1:0]          first_q, end_q, hi_q, slot_q;
	logic [SEGNUM_W-1:0]       seg_q;
	logic [LAYER_W-1:0]        layer_q;
	logic [APOS_W-1:0]         pos_q;
	logic [SEGMENT_BITS-1:0]   bits_q;
	logic [WSEL_W-1:0]         word_q;
	logic                      m_valid_q, m_last_q;
	logic [71:0]               m_data_q;

	logic [PRIME_W-1:0]        prime_mem [PRIME_SLOTS];
	logic [POS_W-1:0]          pos_mem [PRIME_SLOTS*MAX_LAYERS];
	logic [PRIME_W-1:0]        prime_rd_q;
	logic [POS_W-1:0]          pos_rd_q;

	logic [POS_W-1:0]          seg_start;
	logic [CFG_W-1:0]          hi_clip, slot_nxt;
	logic                      div_start, div_done;
	logic [PRIME_W-1:0]        div_rem;
	logic                      hit;
	logic                      out_free;
	logic                      last_go;
	logic [POS_W-1:0]          wb_val;
	logic [APOS_W-OFF_W-1:0]   pos_seg, seg_ext;

	assign acc       = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign seg_start = {seg_q, {OFF_W{1'b0}}};
	assign hi_clip   = (end_q > CFG_W'(PRIME_SLOTS)) ? CFG_W'(PRIME_SLOTS) : end_q;
	assign slot_nxt  = slot_q + 1'b1;
	assign pos_seg   = pos_q[APOS_W-1:OFF_W];
	assign seg_ext   = (APOS_W-OFF_W)'(seg_q);
	assign hit       = (pos_seg == seg_ext);
	assign out_free  = !m_valid_q || m_tready;
	assign last_go   = (state_q == ST_EMIT) && out_free && (word_q == WSEL_W'(SEG_WORDS - 1));
	assign div_start = (state_q == ST_CHK) && (pos_rd_q != NEVER_POS) && (prime_rd_q != '0)
		&& (pos_rd_q < seg_start);
	assign wb_val    = (pos_q >= APOS_W'(NEVER_POS)) ? NEVER_POS : pos_q[POS_W-1:0];

	ssm_rem_unit u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (seg_start - pos_rd_q),
		.divisor   (prime_rd_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (acc && s_tuser == KIND_PRIME)
			prime_mem[in_slot] <= in_prime;
		prime_rd_q <= prime_mem[slot_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (acc && s_tuser == KIND_POS)
			pos_mem[{in_slot, in_layer}] <= in_pos;
		else if (state_q == ST_WB)
			pos_mem[{slot_q[SLOT_W-1:0], layer_q}] <= wb_val;
		pos_rd_q <= pos_mem[{slot_q[SLOT_W-1:0], layer_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			end_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIRST: first_q <= cfg_data;
				REG_END:   end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			m_last_q  <= 1'b0;
			m_data_q  <= '0;
			bits_q    <= '0;
			slot_q    <= '0;
			hi_q      <= '0;
			seg_q     <= '0;
			layer_q   <= '0;
			word_q    <= '0;
			pos_q     <= '0;
		end else begin
			if (m_tready && state_q != ST_EMIT)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc && s_tuser == KIND_SIEVE) begin
						bits_q  <= '0;
						slot_q  <= first_q;
						hi_q    <= hi_clip;
						seg_q   <= in_seg;
						layer_q <= in_layer;
						word_q  <= '0;
						state_q <= (first_q < hi_clip) ? ST_RD : ST_EMIT;
					end
				end
				ST_RD:   state_q <= ST_CHK;
				ST_CHK: begin
					if (pos_rd_q == NEVER_POS || prime_rd_q == '0) begin
						slot_q  <= slot_nxt;
						state_q <= (slot_nxt < hi_q) ? ST_RD : ST_EMIT;
					end else if (div_start) begin
						state_q <= ST_DIV;
					end else begin
						pos_q   <= APOS_W'(pos_rd_q);
						state_q <= ST_MARK;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						pos_q   <= (div_rem == '0) ? APOS_W'(seg_start)
							: APOS_W'(seg_start) + APOS_W'(prime_rd_q - div_rem);
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					if (hit) begin
						bits_q[pos_q[OFF_W-1:0]] <= 1'b1;
						pos_q <= pos_q + APOS_W'(prime_rd_q);
					end else begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					slot_q  <= slot_nxt;
					state_q <= (slot_nxt < hi_q) ? ST_RD : ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_last_q  <= (word_q == WSEL_W'(SEG_WORDS - 1));
						m_data_q  <= {4'b0, bits_q[word_q*BITS_PER_WORD +: BITS_PER_WORD],
							word_q};
						word_q    <= word_q + 1'b1;
						if (word_q == WSEL_W'(SEG_WORDS - 1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	`SSM_ASSERT_IMP(a_mark_in_range, state_q == ST_MARK, pos_seg >= seg_ext, "mark before segment")
	`SSM_ASSERT_NXT(a_last_to_idle, last_go, state_q == ST_IDLE && m_tvalid && m_tlast, "sieve not ended")
	`SSM_ASSERT_IMP(a_rem_bound, div_done, div_rem < prime_rd_q, "remainder not below prime")
endmodule
